// ===== design/dret_pkg.sv =====
// ----------------------------------------------------------------------------
// dret_pkg: shared types, constants and functions of the difficulty retarget
// Widths of the wide target path, the job record and compact decoding.
// ----------------------------------------------------------------------------
package dret_pkg;

   localparam int TargetWidth = 256;
   localparam int NLimb       = (TargetWidth + 31) / 32;
   localparam int AccWidth    = NLimb * 32;
   localparam int NBytes      = AccWidth / 8;
   localparam int SizeW       = $clog2(NBytes + 2);
   localparam int LimbCntW    = $clog2(NLimb);
   localparam int DivCntW     = $clog2(AccWidth);
   localparam int TsW         = 30;
   localparam int ClampShift  = 2;
   localparam int QueueDepth  = 2;
   localparam int QPtrW       = $clog2(QueueDepth);
   localparam int QCntW       = $clog2(QueueDepth + 1);

   typedef logic [AccWidth-1:0] acc_type;

   localparam acc_type TopMask = {AccWidth{1'b1}} >> (AccWidth - TargetWidth);

   // register index, taken from paddr bit 2
   localparam logic RegTimespan = 1'b0;
   localparam logic RegLimit    = 1'b1;

   localparam logic [TsW-1:0] TimespanReset = 30'd1209600;
   localparam logic [31:0]    LimitReset    = 32'd486604799;

   typedef struct packed {
      logic [31:0] span;
      acc_type     target;
   } job_type;

   typedef struct packed {
      logic push;
      logic full;
   } q_status_type;

   // compact word to wide target, sign bit ignored
   function automatic acc_type decode_compact(logic [31:0] bits);
      logic [7:0]  size;
      logic [22:0] word;
      logic [10:0] sh;
      acc_type     t;
      size = bits[31:24];
      word = bits[22:0];
      sh   = {size - 8'd3, 3'b000};
      if (size <= 8'd3) begin
         t = AccWidth'(word >> {2'(8'd3 - size), 3'b000});
      end else begin
         t = AccWidth'(word) << sh;
      end
      return t & TopMask;
   endfunction

endpackage

// ===== design/dret_ifs.sv =====
// ----------------------------------------------------------------------------
// dret_ifs: request and response channels of the difficulty retarget
// Valid/ready handshake, payload carried alongside.
// ----------------------------------------------------------------------------
interface dret_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] last_block_time;
   logic [31:0] first_block_time;
   logic [31:0] last_compact_bits;
   modport source(output valid, last_block_time, first_block_time, last_compact_bits,
                  input ready);
   modport sink(input valid, last_block_time, first_block_time, last_compact_bits,
                output ready);
endinterface

interface dret_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] next_compact_bits;
   modport source(output valid, next_compact_bits, input ready);
   modport sink(input valid, next_compact_bits, output ready);
endinterface

// ===== design/dret_front.sv =====
// ----------------------------------------------------------------------------
// dret_front: request intake
// Clamps the elapsed time and decodes the compact target into a job.
// ----------------------------------------------------------------------------
module dret_front import dret_pkg::*; (
   dret_req_if.sink       req_chan,
   input  logic [TsW-1:0] timespan,
   input  logic           q_full,
   output logic           q_push,
   output job_type        q_job
);

   logic signed [33:0] span_raw;
   logic signed [33:0] span_lo;
   logic signed [33:0] span_hi;
   logic signed [33:0] span_clamped;

   always_comb begin
      span_raw = 34'(req_chan.last_block_time) - 34'(req_chan.first_block_time);
      span_lo  = 34'(timespan >> ClampShift);
      span_hi  = 34'(timespan) <<< ClampShift;
      span_clamped = span_raw;
      if (span_clamped < span_lo) begin
         span_clamped = span_lo;
      end
      if (span_clamped > span_hi) begin
         span_clamped = span_hi;
      end
   end

   assign req_chan.ready = !q_full;
   assign q_push         = req_chan.valid && !q_full;
   assign q_job.span     = span_clamped[31:0];
   assign q_job.target   = decode_compact(req_chan.last_compact_bits);

endmodule

// ===== design/dret_queue.sv =====
// ----------------------------------------------------------------------------
// dret_queue: job queue
// Short register queue between intake and the arithmetic engine.
// ----------------------------------------------------------------------------
module dret_queue import dret_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output logic    not_empty,
   output job_type pop_job
);

   job_type          slot_ff [QueueDepth];
   logic [QPtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCntW-1:0] cnt_ff, cnt_in;

   assign full      = (cnt_ff == QCntW'(QueueDepth));
   assign not_empty = (cnt_ff != '0);
   assign pop_job   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ===== design/dret_back.sv =====
// ----------------------------------------------------------------------------
// dret_back: retarget engine
// Limb-serial multiply, bit-serial divide, cap and compact re-encoding.
// ----------------------------------------------------------------------------
module dret_back import dret_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           q_valid,
   input  job_type        q_job,
   output logic           q_pop,
   input  logic [TsW-1:0] timespan,
   input  logic [31:0]    limit,
   dret_rsp_if.source     rsp_chan
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MUL  = 3'd1;
   localparam logic [2:0] S_DIV  = 3'd2;
   localparam logic [2:0] S_CAP  = 3'd3;
   localparam logic [2:0] S_SIZE = 3'd4;
   localparam logic [2:0] S_ENC  = 3'd5;

   logic [2:0]          state_ff, state_in;
   acc_type             acc_ff, acc_in;
   acc_type             lim_ff, lim_in;
   logic [31:0]         span_ff, span_in;
   logic [31:0]         carry_ff, carry_in;
   logic [TsW-1:0]      rem_ff, rem_in;
   logic [LimbCntW-1:0] limb_cnt_ff, limb_cnt_in;
   logic [DivCntW-1:0]  div_cnt_ff, div_cnt_in;
   logic [SizeW-1:0]    size_ff, size_in;
   logic                out_valid_ff, out_valid_in;
   logic [31:0]         out_bits_ff, out_bits_in;

   logic [63:0]         prod;
   logic [TsW:0]        trial;
   logic                ge;
   acc_type             byte_sel;
   logic [23:0]         mant;
   logic [SizeW-1:0]    size_adj;
   logic                out_free;

   assign out_free = !out_valid_ff || rsp_chan.ready;

   always_comb begin
      prod     = 64'(acc_ff[31:0]) * 64'(span_ff) + 64'(carry_ff);
      trial    = {rem_ff, acc_ff[AccWidth-1]};
      ge       = (trial >= {1'b0, timespan});
      byte_sel = acc_ff >> {size_ff - SizeW'(1), 3'b000};
      if (size_ff <= SizeW'(3)) begin
         mant = 24'(acc_ff[23:0] << {2'(SizeW'(3) - size_ff), 3'b000});
      end else begin
         mant = 24'(acc_ff >> {size_ff - SizeW'(3), 3'b000});
      end
      size_adj = size_ff;
      if (mant[23]) begin
         mant     = {8'd0, mant[23:8]};
         size_adj = size_ff + SizeW'(1);
      end
   end

   always_comb begin
      state_in     = state_ff;
      acc_in       = acc_ff;
      lim_in       = lim_ff;
      span_in      = span_ff;
      carry_in     = carry_ff;
      rem_in       = rem_ff;
      limb_cnt_in  = limb_cnt_ff;
      div_cnt_in   = div_cnt_ff;
      size_in      = size_ff;
      out_valid_in = out_valid_ff && !rsp_chan.ready;
      out_bits_in  = out_bits_ff;
      q_pop        = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop       = 1'b1;
               acc_in      = q_job.target;
               span_in     = q_job.span;
               lim_in      = decode_compact(limit);
               carry_in    = '0;
               limb_cnt_in = '0;
               state_in    = S_MUL;
            end
         end
         S_MUL: begin
            acc_in      = {prod[31:0], acc_ff[AccWidth-1:32]};
            carry_in    = prod[63:32];
            limb_cnt_in = limb_cnt_ff + 1'b1;
            if (limb_cnt_ff == LimbCntW'(NLimb - 1)) begin
               acc_in     = acc_in & TopMask;
               rem_in     = '0;
               div_cnt_in = '0;
               state_in   = S_DIV;
            end
         end
         S_DIV: begin
            // zero divisor gives an all-ones quotient
            rem_in     = ge ? TsW'(trial - {1'b0, timespan}) : trial[TsW-1:0];
            acc_in     = {acc_ff[AccWidth-2:0], ge};
            div_cnt_in = div_cnt_ff + 1'b1;
            if (div_cnt_ff == DivCntW'(AccWidth - 1)) begin
               acc_in   = acc_in & TopMask;
               state_in = S_CAP;
            end
         end
         S_CAP: begin
            if (acc_ff > lim_ff) begin
               acc_in = lim_ff;
            end
            size_in  = SizeW'(NBytes);
            state_in = S_SIZE;
         end
         S_SIZE: begin
            if (size_ff != '0 && byte_sel[7:0] == 8'd0) begin
               size_in = size_ff - SizeW'(1);
            end else begin
               state_in = S_ENC;
            end
         end
         S_ENC: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_bits_in  = {8'(size_adj), mant};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff      <= acc_in;
      lim_ff      <= lim_in;
      span_ff     <= span_in;
      carry_ff    <= carry_in;
      rem_ff      <= rem_in;
      limb_cnt_ff <= limb_cnt_in;
      div_cnt_ff  <= div_cnt_in;
      size_ff     <= size_in;
      out_bits_ff <= out_bits_in;
   end

   assign rsp_chan.valid             = out_valid_ff;
   assign rsp_chan.next_compact_bits = out_bits_ff;

endmodule

// ===== design/difficulty_retarget.sv =====
// ----------------------------------------------------------------------------
// difficulty_retarget: compact-target difficulty retarget
// Each request gives window timestamps and the last compact target; the
// response is the next compact target, clamped, scaled and capped.
// Usage: requests arrive on req_chan (valid/ready), one response per request
// leaves on rsp_chan (valid/ready), in request order. A transfer happens when
// valid and ready are both high. Registers target_timespan (byte address 0)
// and limit_compact (address 4) sit on the csr_ APB port; write them only
// while no request is outstanding.
// Each request runs through limb-serial multiply, a one-bit-per-cycle restoring
// divider, the cap against the limit, a search for the byte size of the result
// and compact encoding. The engine takes a new request only once it is done
// with the last one; a two-entry queue takes new requests while the engine
// works and the result register waits on the receiver.
// When rsp_chan.ready is low the result holds and the engine waits; the
// queue then fills and req_chan.ready drops.
// Reset (synchronous, active high) empties the queue, drops any result and
// restores the register reset values.
// ----------------------------------------------------------------------------
module difficulty_retarget import dret_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   dret_req_if.sink    req_chan,
   dret_rsp_if.source  rsp_chan,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [TsW-1:0] timespan_ff, timespan_in;
   logic [31:0]    limit_ff, limit_in;
   logic           csr_wr;
   q_status_type   q_status;
   job_type        push_job;
   job_type        pop_job;
   logic           q_not_empty;
   logic           q_pop;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      timespan_in = timespan_ff;
      limit_in    = limit_ff;
      if (csr_wr) begin
         unique case (csr_paddr[2])
            RegTimespan: timespan_in = csr_pwdata[TsW-1:0];
            RegLimit:    limit_in    = csr_pwdata;
            default:     timespan_in = timespan_ff;
         endcase
      end
      csr_prdata = (csr_paddr[2] == RegLimit) ? limit_ff : 32'(timespan_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timespan_ff <= TimespanReset;
         limit_ff    <= LimitReset;
      end else begin
         timespan_ff <= timespan_in;
         limit_ff    <= limit_in;
      end
   end

   dret_front u_front (
      .req_chan (req_chan),
      .timespan (timespan_ff),
      .q_full   (q_status.full),
      .q_push   (q_status.push),
      .q_job    (push_job)
   );

   dret_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_status.push),
      .push_job  (push_job),
      .full      (q_status.full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .pop_job   (pop_job)
   );

   dret_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (q_not_empty),
      .q_job    (pop_job),
      .q_pop    (q_pop),
      .timespan (timespan_ff),
      .limit    (limit_ff),
      .rsp_chan (rsp_chan)
   );

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_status.full |-> !q_status.push)
      else $error("push into full queue");

   a_sign_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> !rsp_chan.next_compact_bits[23])
      else $error("result mantissa sign bit set");

   a_ts_write: assert property (@(posedge clock) disable iff (reset)
      (csr_wr && csr_paddr[2] == RegTimespan) |=>
         timespan_ff == $past(csr_pwdata[TsW-1:0]))
      else $error("timespan write lost");

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the difficulty retarget
// Walks several timespan/limit settings, drives directed corner cases and
// random windows with random idling on both channels, and compares every
// response with a 256-bit software prediction of the next compact target.
// ----------------------------------------------------------------------------
module tb_top import dret_pkg::*; ();

   class retarget_scoreboard;
      logic [TsW-1:0] timespan;
      logic [31:0]    limit_bits;
      logic [31:0]    pending[$];
      int             errors;
      int             matched;
      int             capped;

      function new();
         timespan   = TimespanReset;
         limit_bits = LimitReset;
         errors     = 0;
         matched    = 0;
         capped     = 0;
      endfunction

      function logic [255:0] expand(logic [31:0] bits);
         int           sz;
         logic [255:0] w;
         sz = int'(bits[31:24]);
         w  = {233'b0, bits[22:0]};
         if (sz <= 3) begin
            return w >> (8 * (3 - sz));
         end
         return w << (8 * (sz - 3));
      endfunction

      function logic [31:0] compress(logic [255:0] t);
         int          bl;
         int          nb;
         logic [31:0] m;
         bl = 0;
         for (int i = 0; i < 256; i++) if (t[i]) bl = i + 1;
         nb = (bl + 7) / 8;
         if (nb <= 3) begin
            m = t[31:0] << (8 * (3 - nb));
         end else begin
            m = 32'(t >> (8 * (nb - 3)));
         end
         m = m & 32'h00ff_ffff;
         if (m[23]) begin
            m  = m >> 8;
            nb = nb + 1;
         end
         return {nb[7:0], 24'b0} | m;
      endfunction

      function logic [31:0] predict_next(logic [31:0] last_t, logic [31:0] first_t,
                                         logic [31:0] bits);
         longint       span;
         longint       lo;
         longint       hi;
         logic [255:0] t;
         logic [255:0] lim;
         span = longint'(last_t) - longint'(first_t);
         lo   = longint'(timespan) / 4;
         hi   = longint'(timespan) * 4;
         if (span < lo) span = lo;
         if (span > hi) span = hi;
         t = expand(bits) * {224'b0, span[31:0]};
         if (timespan == '0) begin
            t = '1;
         end else begin
            t = t / {226'b0, timespan};
         end
         lim = expand(limit_bits);
         if (t > lim) begin
            t = lim;
            capped++;
         end
         return compress(t);
      endfunction

      function void note_request(logic [31:0] last_t, logic [31:0] first_t,
                                 logic [31:0] bits);
         pending.push_back(predict_next(last_t, first_t, bits));
      endfunction

      function void check_response(logic [31:0] got);
         logic [31:0] want;
         if (pending.size() == 0) begin
            $display("%0t: unexpected response next_compact_bits=%h", $time, got);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (want !== got) begin
            $display("%0t: next_compact_bits mismatch: expected %h, actual %h",
                     $time, want, got);
            errors++;
         end else begin
            matched++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   dret_req_if req_chan();
   dret_rsp_if rsp_chan();

   difficulty_retarget u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan.sink),
      .rsp_chan    (rsp_chan.source),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   retarget_scoreboard sb = new();
   bit quiet;
   bit hold_rsp;
   int sent;

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   initial begin
      reset                      = 1'b1;
      csr_psel                   = 1'b0;
      csr_penable                = 1'b0;
      csr_pwrite                 = 1'b0;
      csr_paddr                  = '0;
      csr_pwdata                 = '0;
      req_chan.valid             = 1'b0;
      req_chan.last_block_time   = '0;
      req_chan.first_block_time  = '0;
      req_chan.last_compact_bits = '0;
      rsp_chan.ready             = 1'b0;
   end

   // transfers are taken from pre-edge values
   always @(posedge clock) begin
      if (!reset && req_chan.valid && req_chan.ready)
         sb.note_request(req_chan.last_block_time, req_chan.first_block_time,
                         req_chan.last_compact_bits);
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         sb.check_response(rsp_chan.next_compact_bits);
   end

   // receiver: random stall bursts, one long hold-off on request
   initial begin
      int n;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_chan.ready = 1'b0;
            repeat (1500) @(negedge clock);
            hold_rsp = 1'b0;
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_chan.ready = 1'b0;
            n = $urandom_range(1, 6);
            repeat (n) @(negedge clock);
         end else begin
            rsp_chan.ready = 1'b1;
            n = $urandom_range(1, 12);
            repeat (n) @(negedge clock);
         end
      end
   end

   task automatic csr_write(logic reg_sel, logic [31:0] value);
      csr_psel    = 1'b1;
      csr_pwrite  = 1'b1;
      csr_penable = 1'b0;
      csr_paddr   = {reg_sel, 2'b00};
      csr_pwdata  = value;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      if (reg_sel == RegTimespan) sb.timespan = value[TsW-1:0];
      else sb.limit_bits = value;
   endtask

   // called at a falling edge; returns at a falling edge after the transfer
   task automatic send_window(logic [31:0] last_t, logic [31:0] first_t,
                              logic [31:0] bits);
      int gap;
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_chan.valid = 1'b0;
         gap = $urandom_range(1, 6);
         repeat (gap) @(negedge clock);
      end
      req_chan.valid             = 1'b1;
      req_chan.last_block_time   = last_t;
      req_chan.first_block_time  = first_t;
      req_chan.last_compact_bits = bits;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
      sent++;
   endtask

   task automatic send_random();
      logic [31:0] first_t;
      logic [31:0] bits;
      longint      reach;
      longint      delta;
      first_t = $urandom;
      bits    = $urandom;
      if ($urandom_range(0, 9) == 0) begin
         send_window($urandom, first_t, bits);
      end else begin
         // mostly sane exponents so the product lands near the limit
         if ($urandom_range(0, 3) != 0) bits[31:24] = 8'($urandom_range(0, 34));
         reach = longint'(sb.timespan) * 5 + 2;
         if (reach > 64'hffff_ffff) reach = 64'hffff_ffff;
         delta = longint'($urandom) % reach;
         send_window(first_t + delta[31:0], first_t, bits);
      end
   endtask

   task automatic drain();
      req_chan.valid = 1'b0;
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   initial begin
      logic [31:0] ts_list[5];
      logic [31:0] lim_list[5];
      ts_list  = '{32'd1, 32'd1073741823, 32'd600, 32'd0, 32'd1209600};
      lim_list = '{32'hffff_ffff, 32'h0000_0000, 32'h207f_ffff, 32'h0, 32'h1d00_ffff};
      ts_list[3]  = $urandom_range(1, 1073741823);
      lim_list[3] = $urandom;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      // reset values: clamp edges, exponent corners, sign bit, cap
      send_window(32'd1209600, 32'd0, 32'h1d00ffff);
      send_window(32'd0, 32'd1209600, 32'h1d00ffff);
      send_window(32'hffff_ffff, 32'd0, 32'h1d00ffff);
      send_window(32'd0, 32'hffff_ffff, 32'h1b0404cb);
      send_window(32'd302400, 32'd0, 32'h1b0404cb);
      send_window(32'd4838400, 32'd0, 32'h1b0404cb);
      send_window(32'd1000, 32'd1000, 32'h0000_0000);
      send_window(32'd1209600, 32'd0, 32'h0100_0012);
      send_window(32'd1209600, 32'd0, 32'h0200_1234);
      send_window(32'd1209600, 32'd0, 32'h0312_3456);
      send_window(32'd1209600, 32'd0, 32'h0480_0000);
      send_window(32'd1209600, 32'd0, 32'h047f_ffff);
      send_window(32'd1209600, 32'd0, 32'h1cff_ffff);
      send_window(32'd1209600, 32'd0, 32'h2000_0001);
      send_window(32'd1209600, 32'd0, 32'h2100_0001);
      send_window(32'd1209600, 32'd0, 32'hff7f_ffff);
      send_window(32'd4838400, 32'd0, 32'h0000_8000);
      send_window(32'h8000_0000, 32'h7fff_ffff, 32'h0580_00ff);
      drain();

      for (int p = 0; p < 5; p++) begin
         csr_write(RegTimespan, ts_list[p]);
         csr_write(RegLimit, lim_list[p]);
         for (int i = 0; i < 400; i++) begin
            if (p == 1 && i == 10) hold_rsp = 1'b1;
            if (p == 4 && i == 200) quiet = 1'b1;
            send_random();
         end
         drain();
      end

      repeat (400) @(negedge clock);
      $display("windows sent: %0d, responses matched: %0d, capped at limit: %0d",
               sent, sb.matched, sb.capped);
      $display("six timespan/limit settings including both extremes and a long stall");
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("difficulty_retarget test passed");
      end else begin
         $display("difficulty_retarget test failed");
      end
      $finish;
   end

   initial begin
      #40000000;
      $display("difficulty_retarget test failed");
      $finish;
   end

endmodule

// ===== difficulty_retarget.f =====
design/dret_pkg.sv
design/dret_ifs.sv
design/dret_front.sv
design/dret_queue.sv
design/dret_back.sv
design/difficulty_retarget.sv
tb/tb_top.sv
